/* src/phosphor_persistence_splat_buffer_defines.svh */
// Assertion helpers for the modules of the splat buffer.
`ifndef PHOSPHOR_PERSISTENCE_SPLAT_BUFFER_DEFINES_SVH
`define PHOSPHOR_PERSISTENCE_SPLAT_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define PPSB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("splat buffer check failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define PPSB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("splat buffer check failed");

`endif

/* src/ppsb_pkg.sv */
package ppsb_pkg;
	localparam int X_W      = 8;
	localparam int Y_W      = 8;
	localparam int ADDR_W   = X_W + Y_W;
	localparam int PIXELS   = 1 << ADDR_W;
	localparam int KDEPTH   = 64;
	localparam int KIDX_W   = 6;
	localparam int CH_W     = 16;
	localparam int PIX_W    = 3 * CH_W;

	localparam logic [CH_W-1:0] CH_MAX = 16'hFF00;
	localparam logic [CH_W-1:0] CH_ONE = 16'h0100;
	localparam logic [8:0]      MAX_DIM = 9'd256;
	localparam logic [6:0]      KDEPTH_L = 7'd64;

	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0] REG_PEN_BLUE     = 3'd2;
	localparam logic [2:0] REG_PEN_GREEN    = 3'd3;
	localparam logic [2:0] REG_PEN_RED      = 3'd4;
	localparam logic [2:0] REG_DECAY        = 3'd5;
	localparam logic [2:0] REG_KLEN         = 3'd6;

	typedef enum logic [1:0] {
		OP_DECAY = 2'd0,
		OP_SPLAT = 2'd1,
		OP_READ  = 2'd2,
		OP_LOAD  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  x_pos;
		logic [7:0]  y_pos;
		logic [15:0] point_weight;
		logic [5:0]  entry_index;
		logic signed [3:0] entry_dy;
		logic signed [3:0] entry_dx;
		logic [15:0] entry_weight;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pixel_blue;
		logic [7:0] pixel_green;
		logic [7:0] pixel_red;
		logic       status;
	} out_item_t;

	typedef struct packed {
		logic [3:0]  dy;
		logic [3:0]  dx;
		logic [15:0] weight;
	} kent_t;
endpackage

/* src/phosphor_persistence_splat_buffer.sv */
// Phosphor persistence buffer: a 256 x 256 frame of 8.8 blue, green and red
// intensities in one single-port-write RAM, worked on by one shared 32 x 16
// multiplier under a small sequencer. After reset the block clears the frame
// with busy high. An item is taken when start is high and busy low; its one
// result appears with done for a single cycle and must be caught then. A
// splat works through each kernel entry, skipping the write for entries
// outside the frame, and a decay pass through each active pixel; both wait
// on the registered RAM reads and share the one multiplier among the three
// channels in turn.
`include "phosphor_persistence_splat_buffer_defines.svh"

module phosphor_persistence_splat_buffer
	import ppsb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	input  logic      cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data,
	output logic      done,
	output out_item_t result
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE,
		S_DEC_RD, S_DEC_LD,
		S_KRD, S_CHK, S_SLD,
		S_MUL, S_ACC, S_WR,
		S_RD_ISSUE, S_RD_DATA
	} state_t;

	state_t state_q;

	logic [8:0]  fw_q, fh_q;
	logic [7:0]  pen_q [3];
	logic [15:0] decay_q;
	logic [6:0]  klen_q;

	in_item_t    in_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]  r_q, c_q;
	logic [6:0]  k_q, n_q;
	logic [1:0]  ch_q;
	logic [CH_W-1:0] pix_q [3];
	logic [31:0] aw_q;
	logic [47:0] prod_q;
	logic        status_q;
	logic        done_q;
	out_item_t   res_q;

	logic [8:0]  act_w, act_h;
	logic [6:0]  n_act;
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic        accept;
	logic        read_hit;
	logic        pix_zero;
	kent_t       kent;
	logic [23:0] krdata;
	logic [PIX_W-1:0] srdata, swdata;
	logic [ADDR_W-1:0] sraddr;
	logic        swe;
	logic [9:0]  cx, cy;
	logic        in_frame;
	logic [16:0] sum;
	logic [CH_W-1:0] cur;

	assign act_w  = (fw_q > MAX_DIM) ? MAX_DIM : fw_q;
	assign act_h  = (fh_q > MAX_DIM) ? MAX_DIM : fh_q;
	assign n_act  = (klen_q > KDEPTH_L) ? KDEPTH_L : klen_q;
	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	assign read_hit = ({1'b0, item.x_pos} < act_w) && ({1'b0, item.y_pos} < act_h);
	assign pix_zero = ({result.pixel_blue, result.pixel_green, result.pixel_red} == 24'd0);

	assign kent = kent_t'(krdata);
	assign cx = {2'b00, in_q.x_pos} + {{6{kent.dx[3]}}, kent.dx};
	assign cy = {2'b00, in_q.y_pos} + {{6{kent.dy[3]}}, kent.dy};
	assign in_frame = !cx[9] && !cy[9] && (cx[8:0] < act_w) && (cy[8:0] < act_h);
	assign cur = pix_q[ch_q];
	assign sum = {1'b0, cur} + {1'b0, prod_q[39:24]};

	always_comb begin
		mul_a = {16'd0, cur};
		mul_b = decay_q;
		if (state_q == S_CHK) begin
			mul_a = {16'd0, kent.weight};
			mul_b = in_q.point_weight;
		end else if (in_q.op == OP_SPLAT) begin
			mul_a = aw_q;
			mul_b = {8'd0, pen_q[ch_q]};
		end
	end

	always_comb begin
		case (state_q)
			S_DEC_RD:   sraddr = {r_q, c_q};
			S_CHK:      sraddr = {cy[7:0], cx[7:0]};
			S_RD_ISSUE: sraddr = {in_q.y_pos, in_q.x_pos};
			default:    sraddr = addr_q;
		endcase
	end

	assign swe    = (state_q == S_CLEAR) || (state_q == S_WR);
	assign swdata = (state_q == S_CLEAR) ? '0 : {pix_q[2], pix_q[1], pix_q[0]};

	ppsb_ram #(.WIDTH(PIX_W), .DEPTH(PIXELS)) u_store (
		.clk   (clk),
		.we    (swe),
		.waddr (addr_q),
		.wdata (swdata),
		.raddr (sraddr),
		.rdata (srdata)
	);

	ppsb_ram #(.WIDTH(24), .DEPTH(KDEPTH)) u_kernel (
		.clk   (clk),
		.we    (accept && (item.op == OP_LOAD)),
		.waddr (item.entry_index),
		.wdata ({item.entry_dy, item.entry_dx, item.entry_weight}),
		.raddr (k_q[KIDX_W-1:0]),
		.rdata (krdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			fw_q     <= 9'd256;
			fh_q     <= 9'd256;
			pen_q[0] <= 8'd255;
			pen_q[1] <= 8'd255;
			pen_q[2] <= 8'd255;
			decay_q  <= 16'd32768;
			klen_q   <= 7'd0;
			addr_q   <= '0;
			done_q   <= 1'b0;
			res_q    <= '0;
			r_q      <= '0;
			c_q      <= '0;
			k_q      <= '0;
			n_q      <= '0;
			ch_q     <= '0;
			status_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			prod_q <= mul_a * mul_b;
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  fw_q     <= cfg_data[8:0];
					REG_FRAME_HEIGHT: fh_q     <= cfg_data[8:0];
					REG_PEN_BLUE:     pen_q[0] <= cfg_data[7:0];
					REG_PEN_GREEN:    pen_q[1] <= cfg_data[7:0];
					REG_PEN_RED:      pen_q[2] <= cfg_data[7:0];
					REG_DECAY:        decay_q  <= cfg_data;
					REG_KLEN:         klen_q   <= cfg_data[6:0];
					default: ;
				endcase
			end
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (&addr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						in_q     <= item;
						status_q <= 1'b0;
						r_q      <= '0;
						c_q      <= '0;
						k_q      <= '0;
						n_q      <= n_act;
						case (item.op)
							OP_DECAY: begin
								if (act_w == '0 || act_h == '0) begin
									done_q  <= 1'b1;
									res_q   <= '0;
								end else begin
									state_q <= S_DEC_RD;
								end
							end
							OP_SPLAT: begin
								if (n_act == '0) begin
									done_q  <= 1'b1;
									res_q   <= '0;
								end else begin
									state_q <= S_KRD;
								end
							end
							OP_READ: begin
								if (read_hit) begin
									state_q <= S_RD_ISSUE;
								end else begin
									done_q  <= 1'b1;
									res_q   <= '0;
								end
							end
							default: begin
								done_q <= 1'b1;
								res_q  <= '0;
							end
						endcase
					end
				end
				S_DEC_RD: begin
					addr_q  <= {r_q, c_q};
					state_q <= S_DEC_LD;
				end
				S_DEC_LD: begin
					pix_q[0] <= srdata[15:0];
					pix_q[1] <= srdata[31:16];
					pix_q[2] <= srdata[47:32];
					ch_q     <= '0;
					state_q  <= S_MUL;
				end
				S_KRD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					// Targets outside the frame are dropped and flagged.
					if (in_frame) begin
						addr_q  <= {cy[7:0], cx[7:0]};
						state_q <= S_SLD;
					end else begin
						status_q <= 1'b1;
						if (k_q + 7'd1 == n_q) begin
							done_q  <= 1'b1;
							res_q   <= '{8'd0, 8'd0, 8'd0, 1'b1};
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 7'd1;
							state_q <= S_KRD;
						end
					end
				end
				S_SLD: begin
					aw_q     <= prod_q[31:0];
					pix_q[0] <= srdata[15:0];
					pix_q[1] <= srdata[31:16];
					pix_q[2] <= srdata[47:32];
					ch_q     <= '0;
					state_q  <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (in_q.op == OP_SPLAT) begin
						pix_q[ch_q] <= (sum > {1'b0, CH_MAX}) ? CH_MAX : sum[15:0];
					end else begin
						pix_q[ch_q] <= (cur < CH_ONE) ? '0 : prod_q[31:16];
					end
					if (ch_q == 2'd2) begin
						state_q <= S_WR;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_WR: begin
					if (in_q.op == OP_SPLAT) begin
						if (k_q + 7'd1 == n_q) begin
							done_q  <= 1'b1;
							res_q   <= '{8'd0, 8'd0, 8'd0, status_q};
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 7'd1;
							state_q <= S_KRD;
						end
					end else if ({1'b0, c_q} + 9'd1 == act_w) begin
						c_q <= '0;
						if ({1'b0, r_q} + 9'd1 == act_h) begin
							done_q  <= 1'b1;
							res_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							r_q     <= r_q + 8'd1;
							state_q <= S_DEC_RD;
						end
					end else begin
						c_q     <= c_q + 8'd1;
						state_q <= S_DEC_RD;
					end
				end
				S_RD_ISSUE: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					done_q  <= 1'b1;
					res_q   <= '{srdata[15:8], srdata[31:24], srdata[47:40], 1'b0};
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PPSB_ASSERT_NOW(a_done_idle, done, !busy)
	`PPSB_ASSERT_NOW(a_status_zero_pix, done && result.status, pix_zero)
	`PPSB_ASSERT_NEXT(a_read_busy, accept && item.op == OP_READ && read_hit, busy && !done)
	`PPSB_ASSERT_NOW(a_clear_quiet, state_q == S_CLEAR, !done)
endmodule

/* src/ppsb_ram.sv */
module ppsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* verif/splat_checker.sv */
`timescale 1ns / 1ps

module splat_checker
	import ppsb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  in_item_t  item,
	input  logic      cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic      done,
	input  out_item_t result,
	output int        errors,
	output int        pending
);
	logic [8:0]  frame_w, frame_h;
	logic [7:0]  pen_b, pen_g, pen_r;
	logic [15:0] decay_mul;
	logic [6:0]  kernel_len;

	logic [CH_W-1:0] frame_store [PIXELS][3];
	kent_t           kernel [KDEPTH];

	out_item_t pixel_results [$];
	out_item_t want;

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic [CH_W-1:0] add_clamped(logic [CH_W-1:0] ch, logic [7:0] pen,
			longint unsigned w);
		longint unsigned sum;
		sum = longint'(ch) + ((longint'(pen) * w) >> 24);
		return (sum > longint'(CH_MAX)) ? CH_MAX : CH_W'(sum);
	endfunction

	// Applies one item to the mirrored frame and kernel, giving its result.
	function automatic out_item_t apply_item(in_item_t it);
		out_item_t res;
		int w, h, n, cx, cy, addr;
		longint unsigned aw;
		logic [CH_W-1:0] v;
		logic [7:0] pens [3];
		res = '0;
		w = (frame_w < MAX_DIM) ? int'(frame_w) : 256;
		h = (frame_h < MAX_DIM) ? int'(frame_h) : 256;
		pens[0] = pen_b;
		pens[1] = pen_g;
		pens[2] = pen_r;
		case (op_t'(it.op))
			OP_DECAY: begin
				for (int r = 0; r < h; r++)
					for (int c = 0; c < w; c++)
						for (int ch = 0; ch < 3; ch++) begin
							v = frame_store[r * 256 + c][ch];
							frame_store[r * 256 + c][ch] = (v < CH_ONE) ? '0 :
								CH_W'((longint'(v) * longint'(decay_mul)) >> 16);
						end
			end
			OP_SPLAT: begin
				n = (kernel_len < KDEPTH_L) ? int'(kernel_len) : KDEPTH;
				for (int k = 0; k < n; k++) begin
					cx = int'(it.x_pos) + int'($signed(kernel[k].dx));
					cy = int'(it.y_pos) + int'($signed(kernel[k].dy));
					if (cx < 0 || cy < 0 || cx >= w || cy >= h) begin
						res.status = 1'b1;
					end else begin
						aw = longint'(kernel[k].weight) * longint'(it.point_weight);
						addr = cy * 256 + cx;
						for (int ch = 0; ch < 3; ch++)
							frame_store[addr][ch] = add_clamped(frame_store[addr][ch],
								pens[ch], aw);
					end
				end
			end
			OP_READ: begin
				if (int'(it.x_pos) < w && int'(it.y_pos) < h) begin
					addr = int'(it.y_pos) * 256 + int'(it.x_pos);
					res.pixel_blue  = frame_store[addr][0][15:8];
					res.pixel_green = frame_store[addr][1][15:8];
					res.pixel_red   = frame_store[addr][2][15:8];
				end
			end
			default: begin
				kernel[it.entry_index] = '{dy: it.entry_dy, dx: it.entry_dx,
					weight: it.entry_weight};
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w <= 9'd256;
			frame_h <= 9'd256;
			pen_b <= 8'd255;
			pen_g <= 8'd255;
			pen_r <= 8'd255;
			decay_mul <= 16'd32768;
			kernel_len <= 7'd0;
			pixel_results.delete();
			pending <= 0;
			for (int i = 0; i < PIXELS; i++)
				for (int ch = 0; ch < 3; ch++)
					frame_store[i][ch] = '0;
		end else begin
			if (done) begin
				if (pixel_results.size() == 0) begin
					report("result with no item outstanding");
				end else begin
					want = pixel_results.pop_front();
					if (result.pixel_blue !== want.pixel_blue)
						report($sformatf("blue %0d, expected %0d", result.pixel_blue,
							want.pixel_blue));
					if (result.pixel_green !== want.pixel_green)
						report($sformatf("green %0d, expected %0d", result.pixel_green,
							want.pixel_green));
					if (result.pixel_red !== want.pixel_red)
						report($sformatf("red %0d, expected %0d", result.pixel_red,
							want.pixel_red));
					if (result.status !== want.status)
						report($sformatf("status %0d, expected %0d", result.status,
							want.status));
				end
			end
			if (start && !busy)
				pixel_results.push_back(apply_item(item));
			pending <= pixel_results.size();
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  frame_w <= cfg_data[8:0];
					REG_FRAME_HEIGHT: frame_h <= cfg_data[8:0];
					REG_PEN_BLUE:     pen_b <= cfg_data[7:0];
					REG_PEN_GREEN:    pen_g <= cfg_data[7:0];
					REG_PEN_RED:      pen_r <= cfg_data[7:0];
					REG_DECAY:        decay_mul <= cfg_data;
					REG_KLEN:         kernel_len <= cfg_data[6:0];
					default: ;
				endcase
			end
		end
	end
endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import ppsb_pkg::*;

	localparam int STALL_LIMIT = 200000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 166;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t item = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic done;
	out_item_t result;
	int errors, pending;

	int sent = 0;
	int returned = 0;
	int stall_cycles = 0;
	int act_w = 256, act_h = 256, act_klen = 0;
	logic [63:0] loaded = '0;
	logic allow_gaps = 1'b1;

	always #4 clk = ~clk;

	phosphor_persistence_splat_buffer i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .result(result)
	);

	splat_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .result(result), .errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		if (done)
			returned++;
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic in_item_t make_item(op_t op, int x, int y, int pw, int idx,
			int dy, int dx, int wt);
		in_item_t it;
		it.op = op;
		it.x_pos = 8'(x);
		it.y_pos = 8'(y);
		it.point_weight = 16'(pw);
		it.entry_index = 6'(idx);
		it.entry_dy = 4'(dy);
		it.entry_dx = 4'(dx);
		it.entry_weight = 16'(wt);
		return it;
	endfunction

	// Start stays high across back-to-back items; send lowers it for random gaps while allow_gaps is set.
	task automatic send(in_item_t it);
		item <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sent++;
		if (it.op == OP_LOAD)
			loaded[it.entry_index] = 1'b1;
		if (allow_gaps && $urandom_range(3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(value);
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (returned != sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(int w, int h, int pb, int pg, int pr, int dm, int kl);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_PEN_BLUE, pb);
		write_reg(REG_PEN_GREEN, pg);
		write_reg(REG_PEN_RED, pr);
		write_reg(REG_DECAY, dm);
		write_reg(REG_KLEN, kl);
		cfg_we <= 1'b0;
		act_w = (w > 256) ? 256 : w;
		act_h = (h > 256) ? 256 : h;
		act_klen = (kl > 64) ? 64 : kl;
	endtask

	function automatic int pick_pen();
		case ($urandom_range(3))
			0: return 0;
			1: return 255;
			default: return $urandom_range(255);
		endcase
	endfunction

	// Coordinates mostly hug the active frame so that splats land near its edges.
	function automatic int pick_coord(int lim);
		if ($urandom_range(3) == 0)
			return $urandom_range(255);
		return $urandom_range(0, (lim + 8 > 255) ? 255 : lim + 8);
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int sel, first_gap;
		it = in_item_t'({$urandom, $urandom});
		sel = $urandom_range(99);
		if (sel < 8)
			it.op = OP_DECAY;
		else if (sel < 55)
			it.op = OP_SPLAT;
		else if (sel < 80)
			it.op = OP_READ;
		else
			it.op = OP_LOAD;
		it.x_pos = 8'(pick_coord(act_w));
		it.y_pos = 8'(pick_coord(act_h));
		if ($urandom_range(4) == 0)
			it.point_weight = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		if ($urandom_range(4) == 0)
			it.entry_weight = 16'hFFFF;
		// A splat may only use kernel entries that have been loaded.
		if (it.op == OP_SPLAT) begin
			first_gap = -1;
			for (int k = act_klen - 1; k >= 0; k--)
				if (!loaded[k])
					first_gap = k;
			if (first_gap >= 0) begin
				it.op = OP_LOAD;
				it.entry_index = 6'(first_gap);
			end
		end
		return it;
	endfunction

	initial begin
		int w, h, kl, dm;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(8, 8, 255, 255, 255, 65535, 4);
		send(make_item(OP_LOAD, 0, 0, 0, 0, 0, 0, 65535));
		send(make_item(OP_LOAD, 0, 0, 0, 1, -8, 7, 65535));
		send(make_item(OP_LOAD, 0, 0, 0, 2, 7, -8, 0));
		send(make_item(OP_LOAD, 0, 0, 0, 3, -1, 1, 32768));
		send(make_item(OP_LOAD, 255, 255, 65535, 63, 7, 7, 1));
		send(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < 3; i++)
			send(make_item(OP_SPLAT, 0, 0, 65535, 0, 0, 0, 0));
		send(make_item(OP_SPLAT, 7, 7, 0, 0, 0, 0, 0));
		send(make_item(OP_SPLAT, 4, 4, 65535, 0, 0, 0, 0));
		send(make_item(OP_SPLAT, 255, 255, 65535, 0, 0, 0, 0));
		send(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0));
		send(make_item(OP_READ, 1, 0, 0, 0, 0, 0, 0));
		send(make_item(OP_READ, 255, 3, 0, 0, 0, 0, 0));
		send(make_item(OP_READ, 7, 255, 0, 0, 0, 0, 0));
		send(make_item(OP_DECAY, 0, 0, 0, 0, 0, 0, 0));
		send(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0));
		drain();

		configure(0, 5, 255, 0, 128, 0, 2);
		send(make_item(OP_SPLAT, 0, 0, 65535, 0, 0, 0, 0));
		send(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0));
		send(make_item(OP_DECAY, 0, 0, 0, 0, 0, 0, 0));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			w = $urandom_range(1, 16);
			h = $urandom_range(1, 16);
			kl = $urandom_range(0, 12);
			dm = $urandom_range(3) == 0 ? 65535 : $urandom_range(65535);
			case (p)
				0: begin w = 511; h = 1; end
				1: begin w = 1; h = 256; dm = 0; end
				2: kl = 64;
				3: begin kl = 127; w = 256; h = 2; end
				4: begin w = 2; h = 300; end
				default: ;
			endcase
			configure(w, h, pick_pen(), pick_pen(), pick_pen(), dm, kl);
			allow_gaps = (p < PHASES - 1);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send(random_item());
			drain();
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

/* phosphor_persistence_splat_buffer.f */
+incdir+src
src/ppsb_pkg.sv
src/ppsb_ram.sv
src/phosphor_persistence_splat_buffer.sv
verif/splat_checker.sv
verif/tb_top.sv
